/* rtl/core/mtne_pkg.sv */
// mtne_pkg: shared types and constants for the track note extractor.
// No dependencies.
package mtne_pkg;

  localparam int unsigned OpenNotesDefault = 16;

  typedef enum logic [3:0] {
    PH_DELTA     = 4'd0,
    PH_STATUS    = 4'd1,
    PH_DATA1     = 4'd2,
    PH_DATA2     = 4'd3,
    PH_META_TYPE = 4'd4,
    PH_LENGTH    = 4'd5,
    PH_SKIP      = 4'd6,
    PH_ENDED     = 4'd7
  } phase_e;

  typedef enum logic [1:0] {
    KIND_NOTE    = 2'd0,
    KIND_EOT     = 2'd1,
    KIND_FULL    = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_e;

  localparam logic [7:0] StatusBit   = 8'h80;
  localparam logic [7:0] DataMask    = 8'h7F;
  localparam logic [7:0] SysHigh     = 8'hF0;
  localparam logic [7:0] MetaStatus  = 8'hFF;
  localparam logic [7:0] MetaEot     = 8'h2F;
  localparam logic [3:0] HiNoteOff   = 4'h8;
  localparam logic [3:0] HiNoteOn    = 4'h9;
  localparam logic [3:0] HiProgram   = 4'hC;
  localparam logic [3:0] HiPressure  = 4'hD;
  localparam logic [7:0] KeyStart    = 8'd64;

  typedef struct packed {
    logic [7:0]  key;
    logic [7:0]  vel;
    logic [31:0] start;
  } note_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic       clear;   // new track: drop all entries
    logic       push;    // append at position count
    logic       remove;  // close the first (oldest) entry with this key
    logic [7:0] key;
    note_t      entry;
  } cell_cmd_t;

endpackage

/* rtl/core/mtne_cell.sv */
// mtne_cell: one slot of the ordered open-note table.
// Depends on mtne_pkg.
module mtne_cell #(
  parameter int unsigned IdxW = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mtne_pkg::cell_cmd_t cmd_i,
  input  logic [IdxW:0]       my_idx_i,
  input  logic [IdxW:0]       count_i,
  input  logic                prior_hit_i,   // some lower slot matches
  input  mtne_pkg::note_t     next_note_i,   // neighbor above
  output logic                hit_o,         // this slot matches
  output logic                chain_o,       // prior_hit or own hit
  output mtne_pkg::note_t     note_o
);
  mtne_pkg::note_t note_q, note_d;
  logic            valid_q, valid_d;
  logic            occupied;

  assign occupied = valid_q && (my_idx_i < count_i);
  assign hit_o    = occupied && (note_q.key == cmd_i.key);
  assign chain_o  = prior_hit_i || hit_o;
  assign note_o   = note_q;

  always_comb begin
    note_d  = note_q;
    valid_d = valid_q;
    if (cmd_i.clear) begin
      valid_d = 1'b0;
    end else if (cmd_i.push && my_idx_i == count_i) begin
      note_d  = cmd_i.entry;
      valid_d = 1'b1;
    end else if (cmd_i.remove && chain_o) begin
      // shift down from the neighbor above
      note_d = next_note_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    note_q <= note_d;
  end
endmodule

/* rtl/core/midi_track_note_extractor.sv */
// Track event parser and note pairing; top level.
// Depends on mtne_pkg and mtne_cell.
// One track byte per transfer; each byte is fully handled when accepted, so the
// block takes a byte every cycle while the output register is free or being
// drained. A note-off searches a chain of OPEN_NOTES cells in parallel: each
// cell compares its key, the first hit and all cells above it shift down by
// one. Results (completed note, end of track, table full, unknown status)
// appear in a registered output stage; at most one per byte. After end of
// track, bytes are swallowed until a byte arrives with new_track set.
module midi_track_note_extractor #(
  parameter int unsigned OPEN_NOTES = mtne_pkg::OpenNotesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        new_track_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  note_key_o,
  output logic [7:0]  note_velocity_o,
  output logic [31:0] start_tick_o,
  output logic [31:0] duration_ticks_o,
  output logic [7:0]  lowest_key_o,
  output logic [7:0]  highest_key_o
);
  localparam int unsigned IdxW = (OPEN_NOTES > 1) ? $clog2(OPEN_NOTES) : 1;
  localparam logic [IdxW:0] Full = (IdxW+1)'(OPEN_NOTES);

  mtne_pkg::phase_e phase_q, phase_d, ph;
  logic [31:0] acc_q, acc_d, wall_q, wall_d, skip_q, skip_d;
  logic [7:0]  run_q, run_d, cur_q, cur_d, first_q, first_d, meta_q, meta_d;
  logic [7:0]  min_q, min_d, max_q, max_d;
  logic [IdxW:0] cnt_q, cnt_d;

  logic       ov_q, ov_d;
  logic [1:0] okind_q, okind_d;
  logic [7:0] okey_q, okey_d, ovel_q, ovel_d, omin_q, omin_d, omax_q, omax_d;
  logic [31:0] ostart_q, ostart_d, odur_q, odur_d;

  logic fire;
  assign ready_o = !ov_q || ready_i;
  assign fire    = valid_i && ready_o;

  // Cell chain
  mtne_pkg::cell_cmd_t cmd;
  mtne_pkg::note_t     notes [OPEN_NOTES];
  logic [OPEN_NOTES-1:0] hits, chain;
  mtne_pkg::note_t     match_note;
  logic                any_hit;

  for (genvar g = 0; g < OPEN_NOTES; g++) begin : g_cell
    mtne_cell #(.IdxW(IdxW)) u_cell (
      .clk_i, .rst_ni,
      .cmd_i       (cmd),
      .my_idx_i    ((IdxW+1)'(g)),
      .count_i     (cnt_q),
      .prior_hit_i ((g == 0) ? 1'b0 : chain[(g == 0) ? 0 : g-1]),
      .next_note_i (notes[(g+1 < OPEN_NOTES) ? g+1 : g]),
      .hit_o       (hits[g]),
      .chain_o     (chain[g]),
      .note_o      (notes[g])
    );
  end

  assign any_hit = chain[OPEN_NOTES-1];

  // Oldest matching entry: the lowest set bit of hits tells where the first hit sits.
  always_comb begin
    match_note = notes[0];
    for (int i = OPEN_NOTES-1; i >= 0; i--) begin
      if (hits[i]) match_note = notes[i];
    end
  end

  logic [7:0] b;
  logic [31:0] acc_sh;
  logic [3:0]  hi;
  logic        emit;
  logic [1:0]  ekind;
  logic [7:0]  ekey, evel;
  logic [31:0] estart, edur;
  logic        voice_end, event_end;
  logic [7:0]  second;
  logic [31:0] wall_c, acc_c;
  logic [7:0]  run_c, cur_c, min_c, max_c;
  logic [IdxW:0] cnt_c;

  always_comb begin
    b = data_byte_i;
    // per-track clear happens before the byte
    ph     = new_track_i ? mtne_pkg::PH_DELTA : phase_q;
    acc_c  = new_track_i ? 32'd0 : acc_q;
    wall_c = new_track_i ? 32'd0 : wall_q;
    run_c  = new_track_i ? 8'd0 : run_q;
    cur_c  = new_track_i ? 8'd0 : cur_q;
    cnt_c  = new_track_i ? '0 : cnt_q;
    min_c  = new_track_i ? mtne_pkg::KeyStart : min_q;
    max_c  = new_track_i ? mtne_pkg::KeyStart : max_q;
    acc_sh = {acc_c[24:0], b[6:0]};

    phase_d = ph;      acc_d = acc_c;   wall_d = wall_c;
    run_d = run_c;     cur_d = cur_c;
    first_d = new_track_i ? 8'd0 : first_q;
    meta_d  = new_track_i ? 8'd0 : meta_q;
    skip_d  = new_track_i ? 32'd0 : skip_q;
    cnt_d = cnt_c;     min_d = min_c;   max_d = max_c;

    emit = 1'b0; ekind = mtne_pkg::KIND_NOTE;
    ekey = '0; evel = '0; estart = '0; edur = '0;
    voice_end = 1'b0; event_end = 1'b0; second = 8'd0;

    cmd = '0;
    cmd.clear = fire && new_track_i;
    cmd.key   = first_q;

    hi = cur_c[7:4];
    unique case (ph)
      mtne_pkg::PH_DELTA: begin
        acc_d = acc_sh;
        if (!b[7]) begin
          wall_d = wall_c + acc_sh; acc_d = '0; phase_d = mtne_pkg::PH_STATUS;
        end
      end
      mtne_pkg::PH_STATUS: begin
        if (b[7]) begin
          cur_d = b;
          if (b[7:4] == mtne_pkg::SysHigh[7:4]) begin
            acc_d = '0;
            phase_d = (b == mtne_pkg::MetaStatus) ? mtne_pkg::PH_META_TYPE
                                                  : mtne_pkg::PH_LENGTH;
          end else begin
            run_d = b; phase_d = mtne_pkg::PH_DATA1;
          end
        end else if (run_c[7] && run_c[7:4] != mtne_pkg::SysHigh[7:4]) begin
          cur_d = run_c; hi = run_c[7:4]; first_d = b;
          if (hi == mtne_pkg::HiProgram || hi == mtne_pkg::HiPressure) voice_end = 1'b1;
          else phase_d = mtne_pkg::PH_DATA2;
        end else begin
          emit = 1'b1; ekind = mtne_pkg::KIND_UNKNOWN;
          acc_d = {25'd0, b[6:0]};
          phase_d = mtne_pkg::PH_DELTA;
          if (!b[7]) begin
            wall_d = wall_c + {25'd0, b[6:0]}; acc_d = '0;
            phase_d = mtne_pkg::PH_STATUS;
          end
        end
      end
      mtne_pkg::PH_DATA1: begin
        first_d = b;
        if (hi == mtne_pkg::HiProgram || hi == mtne_pkg::HiPressure) voice_end = 1'b1;
        else phase_d = mtne_pkg::PH_DATA2;
      end
      mtne_pkg::PH_DATA2: begin
        voice_end = 1'b1; second = b;
      end
      mtne_pkg::PH_META_TYPE: begin
        meta_d = b; acc_d = '0; phase_d = mtne_pkg::PH_LENGTH;
      end
      mtne_pkg::PH_LENGTH: begin
        acc_d = acc_sh;
        if (!b[7]) begin
          skip_d = acc_sh; acc_d = '0;
          if (acc_sh == 32'd0) event_end = 1'b1;
          else phase_d = mtne_pkg::PH_SKIP;
        end
      end
      mtne_pkg::PH_SKIP: begin
        skip_d = (skip_q != 32'd0) ? skip_q - 32'd1 : skip_q;
        if (skip_d == 32'd0) event_end = 1'b1;
      end
      default: ;
    endcase

    if (event_end) begin
      if (cur_d == mtne_pkg::MetaStatus && meta_d == mtne_pkg::MetaEot) begin
        phase_d = mtne_pkg::PH_ENDED; emit = 1'b1; ekind = mtne_pkg::KIND_EOT;
      end else begin
        phase_d = mtne_pkg::PH_DELTA; acc_d = '0;
      end
    end

    if (voice_end) begin
      phase_d = mtne_pkg::PH_DELTA; acc_d = '0;
      if (hi == mtne_pkg::HiNoteOn && second != 8'd0) begin
        if (cnt_c >= Full) begin
          emit = 1'b1; ekind = mtne_pkg::KIND_FULL;
          ekey = first_d; evel = second; estart = wall_c;
        end else begin
          cmd.push = fire;
          cmd.entry = '{key: first_d, vel: second, start: wall_c};
          cnt_d = cnt_c + 1'b1;
        end
      end else if ((hi == mtne_pkg::HiNoteOn || hi == mtne_pkg::HiNoteOff)
                   && any_hit && !new_track_i) begin
        // Note-off in DATA2 (or DATA1 for one-byte? never) keys on first_q.
        cmd.remove = fire;
        cnt_d = cnt_c - 1'b1;
        if (first_q < min_c) min_d = first_q;
        if (first_q > max_c) max_d = first_q;
        emit = 1'b1; ekind = mtne_pkg::KIND_NOTE;
        ekey = first_q; evel = match_note.vel; estart = match_note.start;
        edur = wall_c - match_note.start;
      end
    end

    ov_d = ov_q && !ready_i;
    okind_d = okind_q; okey_d = okey_q; ovel_d = ovel_q; ostart_d = ostart_q;
    odur_d = odur_q; omin_d = omin_q; omax_d = omax_q;
    if (fire && emit) begin
      ov_d = 1'b1; okind_d = ekind; okey_d = ekey; ovel_d = evel;
      ostart_d = estart; odur_d = edur; omin_d = min_d; omax_d = max_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mtne_pkg::PH_DELTA;
      acc_q <= '0; wall_q <= '0; skip_q <= '0;
      run_q <= '0; cur_q <= '0; first_q <= '0; meta_q <= '0;
      cnt_q <= '0;
      min_q <= mtne_pkg::KeyStart; max_q <= mtne_pkg::KeyStart;
      ov_q <= 1'b0;
    end else begin
      if (fire) begin
        phase_q <= phase_d;
        acc_q <= acc_d; wall_q <= wall_d; skip_q <= skip_d;
        run_q <= run_d; cur_q <= cur_d; first_q <= first_d; meta_q <= meta_d;
        cnt_q <= cnt_d; min_q <= min_d; max_q <= max_d;
      end
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    okind_q <= okind_d; okey_q <= okey_d; ovel_q <= ovel_d;
    ostart_q <= ostart_d; odur_q <= odur_d; omin_q <= omin_d; omax_q <= omax_d;
  end

  assign valid_o          = ov_q;
  assign kind_o           = okind_q;
  assign note_key_o       = okey_q;
  assign note_velocity_o  = ovel_q;
  assign start_tick_o     = ostart_q;
  assign duration_ticks_o = odur_q;
  assign lowest_key_o     = omin_q;
  assign highest_key_o    = omax_q;
endmodule

/* tb/midi_note_checker.sv */
// midi_note_checker: predicts and checks the results of the track note extractor.
// Depends on mtne_pkg; watches both channels of the block.
module midi_note_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic        ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        new_track_i,
  input  logic        valid_o,
  input  logic        ready_i,
  input  logic [1:0]  kind_o,
  input  logic [7:0]  note_key_o,
  input  logic [7:0]  note_velocity_o,
  input  logic [31:0] start_tick_o,
  input  logic [31:0] duration_ticks_o,
  input  logic [7:0]  lowest_key_o,
  input  logic [7:0]  highest_key_o,
  output int          error_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = mtne_pkg::OpenNotesDefault;

  typedef struct packed {
    mtne_pkg::kind_e kind;
    logic [7:0]      key;
    logic [7:0]      vel;
    logic [31:0]     start;
    logic [31:0]     dur;
    logic [7:0]      lo;
    logic [7:0]      hi;
  } note_event_t;

  note_event_t expected_events[$];

  mtne_pkg::phase_e phase;
  logic [31:0]      accum, tick, skip_left;
  logic [7:0]       run_status, cur_status, data1, meta_type, min_k, max_k;
  mtne_pkg::note_t  notes[Depth];
  int               n_open;

  assign pending = expected_events.size();

  task automatic clear_parser();
    phase = mtne_pkg::PH_DELTA; accum = 0; tick = 0; skip_left = 0;
    run_status = 0; cur_status = 0; data1 = 0; meta_type = 0;
    n_open = 0; min_k = mtne_pkg::KeyStart; max_k = mtne_pkg::KeyStart;
  endtask

  task automatic push_event(mtne_pkg::kind_e k, logic [7:0] key, logic [7:0] vel,
                            logic [31:0] st, logic [31:0] dur);
    note_event_t e;
    e = '{k, key, vel, st, dur, min_k, max_k};
    expected_events = {expected_events, e};
  endtask

  task automatic take_delta(logic [7:0] b);
    accum = (accum << 7) | {24'd0, b & mtne_pkg::DataMask};
    if (!b[7]) begin
      tick = tick + accum;
      accum = 0;
      phase = mtne_pkg::PH_STATUS;
    end
  endtask

  task automatic end_event();
    if (cur_status == mtne_pkg::MetaStatus && meta_type == mtne_pkg::MetaEot) begin
      phase = mtne_pkg::PH_ENDED;
      push_event(mtne_pkg::KIND_EOT, 0, 0, 0, 0);
    end else begin
      phase = mtne_pkg::PH_DELTA;
      accum = 0;
    end
  endtask

  task automatic finish_voice(logic [7:0] second);
    int i;
    mtne_pkg::note_t hit;
    phase = mtne_pkg::PH_DELTA;
    accum = 0;
    if (cur_status[7:4] == mtne_pkg::HiNoteOn && second != 0) begin
      if (n_open >= Depth) push_event(mtne_pkg::KIND_FULL, data1, second, tick, 0);
      else begin
        notes[n_open] = '{data1, second, tick};
        n_open++;
      end
    end else if (cur_status[7:4] == mtne_pkg::HiNoteOn ||
                 cur_status[7:4] == mtne_pkg::HiNoteOff) begin
      for (i = 0; i < n_open; i++) begin
        if (notes[i].key == data1) begin
          hit = notes[i];
          for (int j = i; j + 1 < n_open; j++) notes[j] = notes[j + 1];
          n_open--;
          if (data1 < min_k) min_k = data1;
          if (data1 > max_k) max_k = data1;
          push_event(mtne_pkg::KIND_NOTE, data1, hit.vel, hit.start, tick - hit.start);
          break;
        end
      end
    end
  endtask

  task automatic first_byte(logic [7:0] b);
    data1 = b;
    if (cur_status[7:4] == mtne_pkg::HiProgram || cur_status[7:4] == mtne_pkg::HiPressure)
      finish_voice(0);
    else phase = mtne_pkg::PH_DATA2;
  endtask

  task automatic predict_byte(logic [7:0] b, logic nt);
    if (nt) clear_parser();
    case (phase)
      mtne_pkg::PH_DELTA: take_delta(b);
      mtne_pkg::PH_STATUS: begin
        if (b[7]) begin
          cur_status = b;
          if ((b & mtne_pkg::SysHigh) == mtne_pkg::SysHigh) begin
            accum = 0;
            phase = (b == mtne_pkg::MetaStatus) ? mtne_pkg::PH_META_TYPE
                                                : mtne_pkg::PH_LENGTH;
          end else begin
            run_status = b;
            phase = mtne_pkg::PH_DATA1;
          end
        end else if (run_status[7] &&
                     (run_status & mtne_pkg::SysHigh) != mtne_pkg::SysHigh) begin
          cur_status = run_status;
          first_byte(b);
        end else begin
          phase = mtne_pkg::PH_DELTA;
          accum = 0;
          take_delta(b);
          push_event(mtne_pkg::KIND_UNKNOWN, 0, 0, 0, 0);
        end
      end
      mtne_pkg::PH_DATA1: first_byte(b);
      mtne_pkg::PH_DATA2: finish_voice(b);
      mtne_pkg::PH_META_TYPE: begin
        meta_type = b; accum = 0; phase = mtne_pkg::PH_LENGTH;
      end
      mtne_pkg::PH_LENGTH: begin
        accum = (accum << 7) | {24'd0, b & mtne_pkg::DataMask};
        if (!b[7]) begin
          skip_left = accum;
          accum = 0;
          if (skip_left == 0) end_event();
          else phase = mtne_pkg::PH_SKIP;
        end
      end
      mtne_pkg::PH_SKIP: begin
        if (skip_left > 0) skip_left--;
        if (skip_left == 0) end_event();
      end
      default: ;
    endcase
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  initial begin
    error_count = 0;
    clear_parser();
  end

  always @(posedge clk_i) begin
    note_event_t w;
    if (rst_ni) begin
      // result first: a byte accepted in this edge shows up later
      if (valid_o && ready_i) begin
        if (expected_events.size() == 0) report("unexpected result", kind_o, 0);
        else begin
          w = expected_events.pop_front();
          if (kind_o != w.kind) report("kind", kind_o, w.kind);
          if (note_key_o != w.key) report("note_key", note_key_o, w.key);
          if (note_velocity_o != w.vel) report("velocity", note_velocity_o, w.vel);
          if (start_tick_o != w.start) report("start_tick", start_tick_o, w.start);
          if (duration_ticks_o != w.dur) report("duration", duration_ticks_o, w.dur);
          if (lowest_key_o != w.lo) report("lowest_key", lowest_key_o, w.lo);
          if (highest_key_o != w.hi) report("highest_key", highest_key_o, w.hi);
        end
      end
      if (valid_i && ready_o) predict_byte(data_byte_i, new_track_i);
    end
  end
endmodule

/* tb/tb_midi_track_note_extractor.sv */
// tb_midi_track_note_extractor: stimulus and verdict for the track note extractor.
// Depends on mtne_pkg, the block and midi_note_checker.
module tb_midi_track_note_extractor;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic [7:0]  data_byte_i = 8'd0;
  logic        new_track_i = 1'b0;
  logic        ready_i = 1'b0;
  logic        ready_o, valid_o;
  logic [1:0]  kind_o;
  logic [7:0]  note_key_o, note_velocity_o, lowest_key_o, highest_key_o;
  logic [31:0] start_tick_o, duration_ticks_o;
  int          error_count, pending;
  int          sent;
  bit          no_gaps;

  always #5 clk_i = ~clk_i;

  midi_track_note_extractor dut (.*);

  midi_note_checker checker_i (.*);

  // Sink: random stall before each result, with gap-free stretches.
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      repeat (w) @(posedge clk_i);
      ready_i <= 1'b1;
      @(posedge clk_i);
      while (!valid_o) @(posedge clk_i);
      ready_i <= 1'b0;
    end
  end

  // One byte transfer, with an idle gap drawn per byte.
  task automatic send_byte(logic [7:0] b, logic nt = 1'b0);
    int w;
    w = no_gaps ? 0 : $urandom_range(0, 11);
    if (w > 0) begin
      valid_i <= 1'b0;
      repeat (w) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    data_byte_i <= b;
    new_track_i <= nt;
    @(posedge clk_i);
    while (!ready_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_delta(logic [31:0] d);
    logic [7:0] grp[$];
    grp.push_front({1'b0, d[6:0]});
    d = d >> 7;
    while (d != 0) begin
      grp.push_front({1'b1, d[6:0]});
      d = d >> 7;
    end
    foreach (grp[i]) send_byte(grp[i]);
  endtask

  task automatic send_note(logic [3:0] hi, logic [7:0] key, logic [7:0] vel);
    send_delta($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200));
    send_byte({hi, 4'($urandom)});
    send_byte(key);
    send_byte(vel);
  endtask

  // Random event: mostly notes, plus other voice, sysex, meta, new-track bytes and noise.
  task automatic random_event();
    int sel, n;
    sel = $urandom_range(0, 99);
    if (sel < 35)
      send_note(mtne_pkg::HiNoteOn, 8'($urandom_range(58, 70)), 8'($urandom_range(1, 255)));
    else if (sel < 60)
      send_note($urandom_range(0, 1) ? mtne_pkg::HiNoteOff : mtne_pkg::HiNoteOn,
                8'($urandom_range(58, 70)), $urandom_range(0, 1) ? 8'd0 : 8'($urandom));
    else if (sel < 68) begin
      send_delta($urandom_range(0, 5));
      send_byte(8'($urandom_range(0, 127)));
      send_byte(8'($urandom));
    end else if (sel < 76) begin
      send_delta($urandom_range(0, 5));
      send_byte({$urandom_range(0, 1) ? 4'hA : 4'hE, 4'($urandom)});
      send_byte(8'($urandom));
      send_byte(8'($urandom));
    end else if (sel < 82) begin
      send_delta($urandom_range(0, 5));
      send_byte({$urandom_range(0, 1) ? mtne_pkg::HiProgram : mtne_pkg::HiPressure,
                 4'($urandom)});
      send_byte(8'($urandom));
    end else if (sel < 90) begin
      n = $urandom_range(0, 4);
      send_delta($urandom_range(0, 5));
      send_byte($urandom_range(0, 1) ? mtne_pkg::MetaStatus
                                     : {4'hF, 4'($urandom_range(0, 14))});
      if (data_byte_i == mtne_pkg::MetaStatus)
        send_byte($urandom_range(0, 9) == 0 ? mtne_pkg::MetaEot : 8'($urandom));
      send_byte(8'(n));
      repeat (n) send_byte(8'($urandom));
    end else if (sel < 95) begin
      send_byte(8'($urandom), 1'b1);
    end else begin
      send_byte(8'($urandom));
    end
  endtask

  // Hold off input until every predicted result has been taken.
  task automatic drain();
    valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    sent = 0;
    no_gaps = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // unknown status with no running status
    send_delta(0);
    send_byte(8'h05);
    // basic note on/off, velocity-zero off, extreme keys and long delta
    send_note(mtne_pkg::HiNoteOn, 8'h00, 8'hFF);
    send_note(mtne_pkg::HiNoteOn, 8'hFF, 8'h01);
    send_note(mtne_pkg::HiNoteOff, 8'h00, 8'h40);
    send_note(mtne_pkg::HiNoteOn, 8'hFF, 8'h00);
    send_delta(32'hFFFF_FFFF);
    // running status note-on then overlong delta (over 32 bits)
    send_byte(8'h3C); send_byte(8'h7F);
    repeat (5) send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(8'h80); send_byte(8'h3C); send_byte(8'h00);
    // unmatched note-off
    send_note(mtne_pkg::HiNoteOff, 8'h11, 8'h00);
    // table full
    for (int i = 0; i < 17; i++) send_note(mtne_pkg::HiNoteOn, 8'(i + 1), 8'(i + 1));
    drain();
    // sysex with long length, then end of track with zero length
    send_delta(1); send_byte(8'hF0); send_byte(8'h81); send_byte(8'h00);
    repeat (128) send_byte(8'h55);
    send_delta(0); send_byte(8'hFF); send_byte(mtne_pkg::MetaEot); send_byte(8'h00);
    send_byte(8'h90); send_byte(8'h12);
    // new track, end of track with payload
    send_byte(8'h00, 1'b1);
    send_byte(mtne_pkg::MetaStatus); send_byte(mtne_pkg::MetaEot); send_byte(8'h02);
    send_byte(8'hAA); send_byte(8'hBB);
    send_byte(8'h00, 1'b1);
    drain();

    while (sent < 1750) begin
      no_gaps = ($urandom_range(0, 7) == 0);
      random_event();
      if ($urandom_range(0, 199) == 0) send_byte(8'h00, 1'b1);
    end
    drain();
    repeat (20) @(posedge clk_i);

    if (error_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule

/* files.f */
rtl/core/mtne_pkg.sv
rtl/core/mtne_cell.sv
rtl/core/midi_track_note_extractor.sv
tb/midi_note_checker.sv
tb/tb_midi_track_note_extractor.sv
